### design/ipa_pkg.sv
// Shared types, constants and helpers of the ID pool allocator.
`default_nettype none
package ipa_pkg;

	localparam int ID_W        = 8;
	localparam int ROW_W       = 4;
	localparam int ROW_BITS    = 16;
	localparam int ROWS        = 16;
	localparam int MAX_IDS_DEF = 256;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic            rd_req;
		logic            pop;
		logic            push;
		logic [ID_W-1:0] push_id;
	} stack_ctrl_t;

	typedef struct packed {
		logic                rd_en;
		logic [ROW_W-1:0]    rd_row;
		logic                wr_en;
		logic [ROW_W-1:0]    wr_row;
		logic [ROW_BITS-1:0] wr_data;
	} live_ctrl_t;

	// index of the lowest set bit of a 16-bit word, 0 when empty
	function automatic logic [ROW_W-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
		logic [ROW_W-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = ROW_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### design/id_pool_allocator_unit.sv
// Top level of the ID pool allocator: command sequencer and result register.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | command, release_id
//   out     | out_valid / out_stall| granted_id, ok, largest_id, fallback_id
//
// A granting allocate goes from accept to result load through live-row read,
// row write, lowest-row read and encode; other commands skip the row-write step.
// The accept edge itself issues the stack read and the speculative row read.
// The input reopens the cycle after the load, so commands are taken one at a time.
// Reset needs no clearing pass: row summary flops mark empty rows.
// A stalled result holds in the output register; a new beat is taken meanwhile
// and waits in the last step until the register frees.
`default_nettype none
module id_pool_allocator_unit import ipa_pkg::*; #(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [ID_W-1:0]   release_id,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [ID_W-1:0]        granted_id,
	output logic                   ok,
	output logic [ID_W-1:0]        largest_id,
	output logic [ID_W-1:0]        fallback_id
);

	// usable IDs are 1 .. ID_LIMIT-1
	localparam int ID_LIMIT = (MAX_IDS < 256) ? MAX_IDS : 256;
	localparam int NW       = $clog2(ID_LIMIT + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_MARK = 5'b00100,
		ST_FIND = 5'b01000,
		ST_SEND = 5'b10000
	} state_t;

	state_t          state_q;
	logic            cmd_q;
	logic [ID_W-1:0] rid_q;
	logic [ID_W-1:0] gid_q;
	logic            ok_q;
	logic [NW-1:0]   next_q;

	stack_ctrl_t         sctl;
	live_ctrl_t          lctl;
	logic                stk_empty;
	logic [ID_W-1:0]     stk_data;
	logic [ROW_BITS-1:0] row_data;
	logic [ROW_W-1:0]    first_row;
	logic                any_live;

	logic                in_acc;
	logic                out_free;
	logic                rel_live;
	logic                rel_top;
	logic [NW-1:0]       next_m1;
	logic [ID_W-1:0]     next_lo;
	logic [ROW_BITS-1:0] rid_mask;
	logic [ROW_BITS-1:0] gid_mask;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign rid_mask = ROW_BITS'(1) << rid_q[ROW_W-1:0];
	assign gid_mask = ROW_BITS'(1) << gid_q[ROW_W-1:0];
	assign rel_live = (rid_q != '0) && ((row_data & rid_mask) != '0);
	assign rel_top  = ((9'(rid_q) + 9'd1) == 9'(next_q));
	assign next_m1  = next_q - NW'(1);
	assign next_lo  = ID_W'(next_q);

	// memory requests per step
	always_comb begin
		sctl        = '0;
		lctl        = '0;
		sctl.push_id = rid_q;
		case (state_q)
			ST_IDLE: begin
				// speculative reads: stack top for allocate, row for release
				sctl.rd_req = in_acc;
				lctl.rd_en  = in_acc;
				lctl.rd_row = release_id[ID_W-1 -: ROW_W];
			end
			ST_LOOK: begin
				if (cmd_q == CMD_ALLOC) begin
					sctl.pop    = !stk_empty;
					lctl.rd_en  = !stk_empty || (next_q < NW'(ID_LIMIT));
					lctl.rd_row = stk_empty ? next_lo[ID_W-1 -: ROW_W]
					                        : stk_data[ID_W-1 -: ROW_W];
				end else if (rel_live) begin
					lctl.wr_en   = 1'b1;
					lctl.wr_row  = rid_q[ID_W-1 -: ROW_W];
					lctl.wr_data = row_data & ~rid_mask;
					sctl.push    = !rel_top;
				end
			end
			ST_MARK: begin
				lctl.wr_en   = 1'b1;
				lctl.wr_row  = gid_q[ID_W-1 -: ROW_W];
				lctl.wr_data = row_data | gid_mask;
			end
			ST_FIND: begin
				lctl.rd_en  = 1'b1;
				lctl.rd_row = first_row;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			next_q    <= NW'(1);
			out_valid <= 1'b0;
		end else begin
			// load wins over the drain of the previous beat
			if (state_q == ST_SEND && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (cmd_q == CMD_ALLOC) begin
						if (!stk_empty) begin
							state_q <= ST_MARK;
						end else if (next_q < NW'(ID_LIMIT)) begin
							next_q  <= next_q + NW'(1);
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_FIND;
						end
					end else begin
						if (rel_live && rel_top) begin
							next_q <= next_m1;
						end
						state_q <= ST_FIND;
					end
				end
				ST_MARK: state_q <= ST_FIND;
				ST_FIND: state_q <= ST_SEND;
				ST_SEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// beat and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			rid_q <= release_id;
		end
		if (state_q == ST_LOOK) begin
			if (cmd_q == CMD_ALLOC) begin
				gid_q <= !stk_empty ? stk_data
				       : (next_q < NW'(ID_LIMIT)) ? ID_W'(next_q) : '0;
				ok_q  <= !stk_empty || (next_q < NW'(ID_LIMIT));
			end else begin
				gid_q <= '0;
				ok_q  <= rel_live;
			end
		end
		if (state_q == ST_SEND && out_free) begin
			granted_id  <= gid_q;
			ok          <= ok_q;
			largest_id  <= ID_W'(next_m1);
			fallback_id <= any_live ? {first_row, lowest_set(row_data)} : '0;
		end
	end

	ipa_free_stack #(
		.DEPTH (ID_LIMIT)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sctl),
		.empty   (stk_empty),
		.rd_data (stk_data)
	);

	ipa_live_map u_live (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (lctl),
		.rd_data   (row_data),
		.first_row (first_row),
		.any_live  (any_live)
	);

endmodule
`default_nettype wire

### design/ipa_free_stack.sv
// LIFO of freed IDs: one synchronous memory plus its fill count.
`default_nettype none
module ipa_free_stack import ipa_pkg::*; #(
	parameter int DEPTH = MAX_IDS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire stack_ctrl_t     ctrl,
	output logic                 empty,
	output logic [ID_W-1:0]      rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [ID_W-1:0] mem [DEPTH];
	logic [AW-1:0]   count_q;

	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (ctrl.rd_req) begin
			rd_data <= mem[count_q - AW'(1)];
		end
		if (ctrl.push) begin
			mem[count_q] <= ctrl.push_id;
		end
	end

	// push and pop never come in the same beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + AW'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - AW'(1);
		end
	end

endmodule
`default_nettype wire

### design/ipa_live_map.sv
// Live bitmap: 16 rows of 16 bits in memory, a row summary and the lowest-row encoder.
`default_nettype none
module ipa_live_map import ipa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire live_ctrl_t          ctrl,
	output logic [ROW_BITS-1:0]      rd_data,
	output logic [ROW_W-1:0]         first_row,
	output logic                     any_live
);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] mem_rd_q;
	logic                rd_valid_q;
	logic [ROWS-1:0]     summary_q;

	// a row whose summary bit is clear reads as empty
	assign rd_data   = rd_valid_q ? mem_rd_q : '0;
	assign first_row = lowest_set(summary_q);
	assign any_live  = |summary_q;

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			mem_rd_q <= mem[ctrl.rd_row];
		end
		if (ctrl.wr_en) begin
			mem[ctrl.wr_row] <= ctrl.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.rd_en) begin
				rd_valid_q <= summary_q[ctrl.rd_row];
			end
			if (ctrl.wr_en) begin
				summary_q[ctrl.wr_row] <= |ctrl.wr_data;
			end
		end
	end

endmodule
`default_nettype wire

### tb/id_pool_mirror_pkg.sv
// Scoreboard for the ID pool allocator: predicts each result beat and checks the block's output.
`timescale 1ns / 100ps
package id_pool_mirror_pkg;
	import ipa_pkg::*;

	localparam int ID_LIMIT = (MAX_IDS_DEF < 256) ? MAX_IDS_DEF : 256;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            ok;
		logic [ID_W-1:0] largest_id;
		logic [ID_W-1:0] fallback_id;
	} pool_result_t;

	class id_pool_mirror;
		logic [ID_W-1:0] stacked_ids [256];
		int unsigned     free_depth;
		int unsigned     high_water;
		bit              live [256];
		pool_result_t    due_results [$];
		int unsigned     mismatches, checked;
		int unsigned     grants, pops, exhausted, drops, pushes, refused;

		function new();
			free_depth = 0;
			high_water = 1;
			foreach (live[i]) live[i] = 1'b0;
			mismatches = 0;
			checked = 0;
			grants = 0;
			pops = 0;
			exhausted = 0;
			drops = 0;
			pushes = 0;
			refused = 0;
		endfunction

		function logic [ID_W-1:0] lowest_live();
			for (int i = 1; i < 256; i++) begin
				if (live[i]) return ID_W'(i);
			end
			return '0;
		endfunction

		// update the mirrored pool for one accepted command and queue its result
		function void apply_command(logic cmd, logic [ID_W-1:0] rid);
			pool_result_t res;
			res = '0;
			if (cmd == CMD_ALLOC) begin
				if (free_depth > 0) begin
					free_depth--;
					res.granted_id = stacked_ids[free_depth];
					res.ok = 1'b1;
					pops++;
				end else if (high_water < ID_LIMIT) begin
					res.granted_id = ID_W'(high_water);
					high_water++;
					res.ok = 1'b1;
				end else begin
					exhausted++;
				end
				if (res.ok) begin
					live[res.granted_id] = 1'b1;
					grants++;
				end
			end else if (rid != '0 && live[rid]) begin
				live[rid] = 1'b0;
				res.ok = 1'b1;
				if (int'(rid) + 1 == int'(high_water)) begin
					high_water--;
					drops++;
				end else if (free_depth < 256) begin
					stacked_ids[free_depth] = rid;
					free_depth++;
					pushes++;
				end
			end else begin
				refused++;
			end
			res.largest_id = ID_W'(high_water - 1);
			res.fallback_id = lowest_live();
			due_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [ID_W-1:0] want_v,
				logic [ID_W-1:0] got_v);
			if (want_v !== got_v) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			end
		endfunction

		function void check_result(logic [ID_W-1:0] granted_id, logic ok,
				logic [ID_W-1:0] largest_id, logic [ID_W-1:0] fallback_id);
			pool_result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat: granted %0d ok %0d largest %0d fallback %0d",
					$time, granted_id, ok, largest_id, fallback_id);
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("granted_id", want.granted_id, granted_id);
			compare_field("ok", ID_W'(want.ok), ID_W'(ok));
			compare_field("largest_id", want.largest_id, largest_id);
			compare_field("fallback_id", want.fallback_id, fallback_id);
		endfunction

		// a live id picked at random, or any id when nothing is live
		function logic [ID_W-1:0] random_live();
			logic [ID_W-1:0] ids [$];
			for (int i = 1; i < 256; i++) begin
				if (live[i]) ids.push_back(ID_W'(i));
			end
			if (ids.size() == 0) return ID_W'($urandom_range(0, 255));
			return ids[$urandom_range(0, ids.size() - 1)];
		endfunction

		function logic [ID_W-1:0] top_id();
			return ID_W'(high_water - 1);
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction
	endclass

endpackage

### tb/id_pool_allocator_unit_tb.sv
// Testbench of the ID pool allocator: directed and random commands against a scoreboard.
`timescale 1ns / 100ps
module id_pool_allocator_unit_tb;
	import ipa_pkg::*;
	import id_pool_mirror_pkg::*;

	// worst case is far below this: ~1200 beats, each with its idle gap, pipeline
	// and receiver stall, plus one long hold
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 80;   // receiver hold-off that backs up the pipe
	localparam int DRAIN_CYCLES = 20;   // settle time after the last result

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic            command;
	logic [ID_W-1:0] release_id;
	logic            out_valid;
	logic            out_stall;
	logic [ID_W-1:0] granted_id;
	logic            ok;
	logic [ID_W-1:0] largest_id;
	logic [ID_W-1:0] fallback_id;

	id_pool_mirror mirror;
	bit            calm_tail = 1'b0;   // no idling on either side once set
	bit            hold_done = 1'b0;
	int unsigned   cycles = 0;

	always #6 clk = ~clk;

	id_pool_allocator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.release_id  (release_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted_id  (granted_id),
		.ok          (ok),
		.largest_id  (largest_id),
		.fallback_id (fallback_id)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("id_pool_allocator_unit verification failed");
			$finish;
		end
	end

	// result side: every accepted beat is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			mirror.check_result(granted_id, ok, largest_id, fallback_id);
		end
	end

	// receiver stall: random bursts, plus one long hold while the sender keeps
	// offering, so the pipe fills and the input side has to stall
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && mirror.checked >= 150) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall = 1'b0;
				hold_done = 1'b1;
			end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// one input beat; called at a falling edge, returns at a falling edge
	// with valid dropped (the next call raises it again in the same step)
	task automatic send_beat(input logic cmd, input logic [ID_W-1:0] rid);
		command    = cmd;
		release_id = rid;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		mirror.apply_command(cmd, rid);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic await_drain();
		while (mirror.pending() != 0) @(negedge clk);
	endtask

	// random traffic: percentages of allocates, releases of live ids and
	// releases of the current top id; the rest are releases of any id
	task automatic run_phase(input int unsigned beats, input int unsigned alloc_pct,
			input int unsigned live_pct, input int unsigned top_pct, input bit idling);
		int unsigned     pick;
		logic            cmd;
		logic [ID_W-1:0] rid;
		repeat (beats) begin
			if (idling && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			cmd  = CMD_RELEASE;
			rid  = ID_W'($urandom_range(0, 255));
			if (pick < alloc_pct) begin
				cmd = CMD_ALLOC;
			end else if (pick < alloc_pct + live_pct) begin
				rid = mirror.random_live();
			end else if (pick < alloc_pct + live_pct + top_pct) begin
				rid = mirror.top_id();
			end
			send_beat(cmd, rid);
		end
	endtask

	initial begin
		mirror     = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_ALLOC;
		release_id = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: bad releases on an empty pool
		send_beat(CMD_RELEASE, 8'd0);
		send_beat(CMD_RELEASE, 8'd255);
		// fresh ids from the counter
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_ALLOC, 8'd0);
		// middle id goes on the free stack, then a double free
		send_beat(CMD_RELEASE, 8'd2);
		send_beat(CMD_RELEASE, 8'd2);
		// top ids drop the counter; 2 stays stacked while largest names it
		send_beat(CMD_RELEASE, 8'd4);
		send_beat(CMD_RELEASE, 8'd3);
		send_beat(CMD_ALLOC, 8'd0);       // pops 2
		send_beat(CMD_ALLOC, 8'd0);       // counter again
		// lowest live id moves up, then back down on the pop
		send_beat(CMD_RELEASE, 8'd1);
		send_beat(CMD_RELEASE, 8'd0);
		send_beat(CMD_ALLOC, 8'd255);     // release_id ignored here
		send_beat(CMD_RELEASE, 8'd128);   // above the counter
		// unwind everything through counter drops
		send_beat(CMD_RELEASE, 8'd3);
		send_beat(CMD_RELEASE, 8'd2);
		send_beat(CMD_RELEASE, 8'd1);
		send_beat(CMD_ALLOC, 8'd0);
		send_beat(CMD_RELEASE, 8'd1);
		await_drain();

		// mixed traffic; the long receiver hold lands in here
		run_phase(300, 55, 35, 5, 1'b1);
		// sender pause until the pipe is empty
		await_drain();
		repeat ($urandom_range(1, 9)) @(negedge clk);
		// fill the pool to exhaustion and keep knocking on it
		run_phase(320, 90, 8, 0, 1'b1);
		// drain: deep free stack, many counter drops
		run_phase(300, 15, 60, 15, 1'b1);
		// back-to-back tail with no idling
		calm_tail = 1'b1;
		run_phase(230, 50, 35, 10, 1'b0);

		await_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d grants (%0d from the free stack), %0d allocs on a full pool",
			mirror.checked, mirror.grants, mirror.pops, mirror.exhausted);
		$display("releases: %0d stacked, %0d counter drops, %0d refused",
			mirror.pushes, mirror.drops, mirror.refused);
		if (mirror.mismatches == 0 && mirror.pending() == 0) begin
			$display("id_pool_allocator_unit verification clean");
		end else begin
			$display("id_pool_allocator_unit verification failed");
		end
		$finish;
	end

endmodule
